>>> rtl/pbi_pkg.sv
// ----------------------------------------------------------------------------
// pbi_pkg
// shared types for the palette builder and indexer: controller states and the
// command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package pbi_pkg;

   localparam int unsigned COLOR_W = 24;
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned INDEX_W = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic advance;
      logic hit;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic match;
      logic at_end;
      logic out_free;
   } sts_type;

endpackage

>>> rtl/palette_builder_indexer.sv
// ----------------------------------------------------------------------------
// palette_builder_indexer
// exact color palette indexing: each pixel is matched against a palette of
// distinct colors in first-seen order, appended when new, cleared after the
// last pixel of an image
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  red, green, blue, last_of_image
//   rsp      out        rsp_valid/rsp_stall  color_index, is_new_entry,
//                                            overflow, last_out
//
// each pixel is compared against the palette entries in order, stopping at the
// first match or the last entry; the palette memory is read one entry per
// cycle through its single registered read port
// reset empties the palette at once, no clearing pass
// a stalled result sits in the output register while the next pixel is
// taken and scanned; the pixel then waits for the register to free up
// ----------------------------------------------------------------------------
module palette_builder_indexer
   import pbi_pkg::*;
#(
   parameter int unsigned PALETTE_DEPTH = 256
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CHAN_W-1:0]  req_red,
   input  logic [CHAN_W-1:0]  req_green,
   input  logic [CHAN_W-1:0]  req_blue,
   input  logic               req_last_of_image,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [INDEX_W-1:0] rsp_color_index,
   output logic               rsp_is_new_entry,
   output logic               rsp_overflow,
   output logic               rsp_last_out
);

   cmd_type cmd;
   sts_type sts;

   pbi_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pbi_datapath #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_red           (req_red),
      .req_green         (req_green),
      .req_blue          (req_blue),
      .req_last_of_image (req_last_of_image),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_color_index   (rsp_color_index),
      .rsp_is_new_entry  (rsp_is_new_entry),
      .rsp_overflow      (rsp_overflow),
      .rsp_last_out      (rsp_last_out)
   );

endmodule

>>> rtl/pbi_control.sv
// ----------------------------------------------------------------------------
// pbi_control
// sequencer for one pixel: accept, scan the palette memory one entry per cycle
// unless the palette is empty, then hand the result to the output register
// ----------------------------------------------------------------------------
module pbi_control
   import pbi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.count_zero ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.match || sts.at_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.hit     = sts.match;
            cmd.advance = !sts.match && !sts.at_end;
         end
         ST_DONE: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // a scan never starts on an empty palette
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !sts.count_zero)
      else $error("scan with empty palette");

   // commit happens only from the result state
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (state_ff == ST_IDLE))
      else $error("commit did not return to idle");

   // a hit or end of scan always leads to the result state
   assert property (@(posedge clock) disable iff (reset)
      (cmd.hit || ((state_ff == ST_SCAN) && sts.at_end)) |=> (state_ff == ST_DONE))
      else $error("scan end not followed by result state");

endmodule

>>> rtl/pbi_datapath.sv
// ----------------------------------------------------------------------------
// pbi_datapath
// palette memory with registered read, fill count, scan counter, pixel
// register and result output register
// ----------------------------------------------------------------------------
module pbi_datapath
   import pbi_pkg::*;
#(
   parameter int unsigned PALETTE_DEPTH = 256
)(
   input  logic                clock,
   input  logic                reset,
   input  logic [CHAN_W-1:0]   req_red,
   input  logic [CHAN_W-1:0]   req_green,
   input  logic [CHAN_W-1:0]   req_blue,
   input  logic                req_last_of_image,
   input  cmd_type             cmd,
   output sts_type             sts,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [INDEX_W-1:0]  rsp_color_index,
   output logic                rsp_is_new_entry,
   output logic                rsp_overflow,
   output logic                rsp_last_out
);

   localparam int unsigned IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(PALETTE_DEPTH + 1);
   localparam int unsigned EXT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(PALETTE_DEPTH);

   logic [COLOR_W-1:0] mem [PALETTE_DEPTH];
   logic [COLOR_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]   rd_addr;

   logic [COLOR_W-1:0] pixel_ff;
   logic               last_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [IDX_W-1:0]   idx_in;
   logic               found_ff;
   logic               found_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [INDEX_W-1:0] index_ff;
   logic               new_ff;
   logic               ovf_ff;
   logic               last_out_ff;

   logic               room;
   logic               append;
   logic [IDX_W-1:0]   res_idx;
   logic [EXT_W-1:0]   res_ext;

   assign room    = count_ff < DEPTH_C;
   assign append  = !found_ff && room;
   assign res_idx = found_ff ? idx_ff : (room ? count_ff[IDX_W-1:0] : '0);
   assign res_ext = EXT_W'(res_idx);
   assign rd_addr = cmd.load ? '0 : idx_ff + IDX_W'(1);

   assign sts.count_zero = (count_ff == '0);
   assign sts.match      = (rd_data_ff == pixel_ff);
   assign sts.at_end     = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   // palette memory
   always_ff @(posedge clock) begin
      if (cmd.commit && append) begin
         mem[count_ff[IDX_W-1:0]] <= pixel_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      idx_in   = idx_ff;
      found_in = found_ff;
      if (cmd.load) begin
         idx_in   = '0;
         found_in = 1'b0;
      end else if (cmd.advance) begin
         idx_in = idx_ff + IDX_W'(1);
      end else if (cmd.hit) begin
         found_in = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit) begin
         if (last_ff) begin
            count_in = '0;
         end else if (append) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pixel_ff <= {req_red, req_green, req_blue};
         last_ff  <= req_last_of_image;
      end
      if (cmd.commit) begin
         index_ff    <= res_ext[INDEX_W-1:0];
         new_ff      <= append;
         ovf_ff      <= !found_ff && !room;
         last_out_ff <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_color_index  = index_ff;
   assign rsp_is_new_entry = new_ff;
   assign rsp_overflow     = ovf_ff;
   assign rsp_last_out     = last_out_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("palette count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(new_ff && ovf_ff))
      else $error("new entry and overflow together");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && last_ff) |=> (count_ff == '0))
      else $error("palette not cleared after last pixel");

   assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && !last_ff && append) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("append did not grow palette");

endmodule

>>> verif/tb_palette_builder_indexer.sv
// ----------------------------------------------------------------------------
// tb_palette_builder_indexer
// self-checking bench for the exact color palette indexer: a short scripted
// stream of pixels covers first entries, exact matches, one-bit near misses and
// the palette clear after the last pixel of an image; random images follow,
// among them images with more distinct colors than the palette holds. Every
// accepted pixel runs through a shadow palette kept in the bench, and every
// result is compared field by field in order. Both sides idle at random, the
// receiver once holds off long enough to back the block up, and the sender
// now and then waits for all results to drain.
// ----------------------------------------------------------------------------
module tb_palette_builder_indexer
   import pbi_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PAL_DEPTH    = 256;
   localparam int          RANDOM_ITEMS = 1200;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          WATCHDOG     = 5000;
   localparam int          TAIL_CYCLES  = 300;
   localparam int          SCRIPT_LEN   = 21;
   localparam int          MAX_REPORTS  = 10;

   typedef struct packed {
      logic [INDEX_W-1:0] color_index;
      logic               is_new_entry;
      logic               overflow;
      logic               last_out;
   } index_result_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic              last;
      logic              typed;
      index_result_type  res;
   } script_row_type;

   localparam index_result_type NONE = '0;

   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd0, 1'b1, 1'b0, 1'b0}},
      '{8'h00, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0}},
      '{8'hff, 8'hff, 8'hff, 1'b0, 1'b1, '{8'd1, 1'b1, 1'b0, 1'b0}},
      '{8'hff, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd2, 1'b1, 1'b0, 1'b0}},
      '{8'h00, 8'hff, 8'h00, 1'b0, 1'b1, '{8'd3, 1'b1, 1'b0, 1'b0}},
      '{8'h00, 8'h00, 8'hff, 1'b0, 1'b1, '{8'd4, 1'b1, 1'b0, 1'b0}},
      '{8'hff, 8'hff, 8'hff, 1'b0, 1'b1, '{8'd1, 1'b0, 1'b0, 1'b0}},
      '{8'h00, 8'h00, 8'h01, 1'b0, 1'b1, '{8'd5, 1'b1, 1'b0, 1'b0}},
      '{8'h80, 8'h00, 8'h00, 1'b0, 1'b1, '{8'd6, 1'b1, 1'b0, 1'b0}},
      '{8'h01, 8'h00, 8'h00, 1'b0, 1'b0, NONE},
      '{8'h00, 8'h80, 8'h00, 1'b0, 1'b0, NONE},
      '{8'h00, 8'h00, 8'hff, 1'b1, 1'b1, '{8'd4, 1'b0, 1'b0, 1'b1}},
      '{8'hff, 8'hff, 8'hff, 1'b0, 1'b1, '{8'd0, 1'b1, 1'b0, 1'b0}},
      '{8'h12, 8'h34, 8'h56, 1'b1, 1'b1, '{8'd1, 1'b1, 1'b0, 1'b1}},
      '{8'h12, 8'h34, 8'h56, 1'b0, 1'b1, '{8'd0, 1'b1, 1'b0, 1'b0}},
      '{8'h12, 8'h34, 8'h56, 1'b1, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b1}},
      '{8'h55, 8'haa, 8'h55, 1'b1, 1'b1, '{8'd0, 1'b1, 1'b0, 1'b1}},
      '{8'haa, 8'h55, 8'haa, 1'b0, 1'b0, NONE},
      '{8'haa, 8'h55, 8'hab, 1'b0, 1'b0, NONE},
      '{8'hab, 8'h55, 8'haa, 1'b0, 1'b0, NONE},
      '{8'haa, 8'h55, 8'haa, 1'b1, 1'b0, NONE}
   };

   logic               clock             = 1'b0;
   logic               reset             = 1'b1;
   logic               req_valid         = 1'b0;
   logic               req_stall;
   logic [CHAN_W-1:0]  req_red           = '0;
   logic [CHAN_W-1:0]  req_green         = '0;
   logic [CHAN_W-1:0]  req_blue          = '0;
   logic               req_last_of_image = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall         = 1'b0;
   logic [INDEX_W-1:0] rsp_color_index;
   logic               rsp_is_new_entry;
   logic               rsp_overflow;
   logic               rsp_last_out;

   // scripted answer riding along with the pixel on the wire
   logic               row_typed         = 1'b0;
   index_result_type   row_answer        = '0;

   logic [COLOR_W-1:0] shadow_colors [PAL_DEPTH];
   int unsigned        shadow_count      = 0;
   index_result_type   awaited [$];
   int                 mismatches        = 0;
   int                 idle_cycles       = 0;
   int                 items_sent        = 0;
   bit                 quiet             = 1'b0;
   bit                 hold_req          = 1'b0;

   palette_builder_indexer #(
      .PALETTE_DEPTH(PAL_DEPTH)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .req_last_of_image(req_last_of_image),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_color_index  (rsp_color_index),
      .rsp_is_new_entry (rsp_is_new_entry),
      .rsp_overflow     (rsp_overflow),
      .rsp_last_out     (rsp_last_out)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic index_result_type index_color(input logic [COLOR_W-1:0] color,
                                                    input logic last);
      index_result_type res;
      bit               found;
      found = 1'b0;
      res   = '0;
      res.last_out = last;
      for (int unsigned i = 0; i < shadow_count; i++) begin
         if (!found && shadow_colors[i] == color) begin
            res.color_index = INDEX_W'(i);
            found = 1'b1;
         end
      end
      if (!found) begin
         if (shadow_count < PAL_DEPTH) begin
            res.color_index = INDEX_W'(shadow_count);
            res.is_new_entry = 1'b1;
            shadow_colors[shadow_count] = color;
            shadow_count++;
         end else begin
            res.overflow = 1'b1;
         end
      end
      if (last) begin
         shadow_count = 0;
      end
      return res;
   endfunction

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 40);
   endfunction

   task automatic flag_mismatch(input string what, input index_result_type got,
                                input index_result_type want);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch (%0s): got idx %0d new %b ovf %b last %b,",
                  what, got.color_index, got.is_new_entry, got.overflow, got.last_out);
         $display("   expected idx %0d new %b ovf %b last %b",
                  want.color_index, want.is_new_entry, want.overflow, want.last_out);
      end
   endtask

   always @(posedge clock) begin : watch
      index_result_type got;
      index_result_type want;
      bit               moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            got = '{rsp_color_index, rsp_is_new_entry, rsp_overflow, rsp_last_out};
            if (awaited.size() == 0) begin
               flag_mismatch("result with nothing pending", got, NONE);
            end else begin
               want = awaited.pop_front();
               if (got.color_index !== want.color_index ||
                   got.is_new_entry !== want.is_new_entry ||
                   got.overflow !== want.overflow ||
                   got.last_out !== want.last_out) begin
                  flag_mismatch("field", got, want);
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            want = index_color({req_red, req_green, req_blue}, req_last_of_image);
            if (row_typed) begin
               want = row_answer;
            end
            awaited.push_back(want);
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin : rsp_side
      int n;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            n = idle_span();
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   task automatic send_pixel(input logic [COLOR_W-1:0] color, input logic last,
                             input logic typed, input index_result_type answer);
      int n;
      n = idle_span();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_red           <= color[23:16];
      req_green         <= color[15:8];
      req_blue          <= color[7:0];
      req_last_of_image <= last;
      row_typed         <= typed;
      row_answer        <= answer;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited.size() != 0) @(posedge clock);
   endtask

   // more distinct colors than the palette holds, with repeats mixed in
   task automatic send_fill_image();
      logic [COLOR_W-1:0] base;
      logic [COLOR_W-1:0] c;
      logic [COLOR_W-1:0] seen [$];
      int                 fresh_n;
      int                 target;
      base    = COLOR_W'($urandom);
      fresh_n = 0;
      target  = PAL_DEPTH + $urandom_range(4, 16);
      while (fresh_n < target) begin
         if (seen.size() > 0 && $urandom_range(0, 4) == 0) begin
            c = seen[$urandom_range(0, seen.size() - 1)];
         end else begin
            c = base + COLOR_W'(fresh_n) * 24'h9e3779;
            seen.push_back(c);
            fresh_n++;
         end
         send_pixel(c, 1'b0, 1'b0, NONE);
      end
      send_pixel(seen[$urandom_range(0, seen.size() - 1)], 1'b1, 1'b0, NONE);
   endtask

   task automatic send_image();
      logic [COLOR_W-1:0] pool [$];
      logic [COLOR_W-1:0] c;
      int                 len;
      int                 k;
      int                 r;
      bit                 marked;
      k = $urandom_range(1, 12);
      for (int i = 0; i < k; i++) begin
         pool.push_back(COLOR_W'($urandom));
      end
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      marked = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < len; i++) begin
         r = $urandom_range(0, 99);
         c = pool[$urandom_range(0, k - 1)];
         if (r >= 88) begin
            c = COLOR_W'($urandom);
         end else if (r >= 75) begin
            c = c ^ (24'h1 << $urandom_range(0, COLOR_W - 1));
         end
         send_pixel(c, marked && i == len - 1, 1'b0, NONE);
      end
   endtask

   initial begin : stimulus
      int image_no;
      int fills_done;
      image_no   = 0;
      fills_done = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_LEN; i++) begin
         send_pixel({SCRIPT[i].red, SCRIPT[i].green, SCRIPT[i].blue}, SCRIPT[i].last,
                    SCRIPT[i].typed, SCRIPT[i].res);
      end
      wait_drained();

      while (items_sent < SCRIPT_LEN + RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 99) < 15);
         // receiver backs off while pixels keep coming
         if (image_no == 2) begin
            hold_req = 1'b1;
         end
         if (image_no == 0 || (fills_done < 2 && $urandom_range(0, 39) == 0)) begin
            send_fill_image();
            fills_done++;
         end else begin
            send_image();
         end
         if ($urandom_range(0, 9) == 0) begin
            wait_drained();
         end
         image_no++;
      end

      quiet = 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/pbi_pkg.sv
rtl/pbi_control.sv
rtl/pbi_datapath.sv
rtl/palette_builder_indexer.sv
verif/tb_palette_builder_indexer.sv
